@@ sv/tspd_pkg.sv @@
package tspd_pkg;

	localparam int OPCODE_W     = 2;
	localparam int BYTE_W       = 8;
	localparam int STATUS_W     = 3;
	localparam int SUM_W        = 16;
	localparam int CHECK_W      = 17;
	localparam int DCNT_W       = 3;

	localparam int TABLE_SIZE   = 203;
	localparam int TAB_IDX_W    = $clog2(TABLE_SIZE);
	localparam int TABLE_FIRST  = 51;
	localparam int TABLE_LAST   = 253;
	localparam int EOD_MARK     = 33;
	localparam int NIB_BASE     = 35;
	localparam int V2_MARK      = 254;
	localparam int DIGIT_FIRST  = 48;
	localparam int DIGIT_LAST   = 57;
	localparam int CHECK_DIGITS = 5;

	typedef enum logic [OPCODE_W-1:0] {
		OP_DATA  = 2'd0,
		OP_FIRST = 2'd1,
		OP_CONT  = 2'd2,
		OP_END   = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_RUN      = 3'd0,
		ST_GOOD     = 3'd1,
		ST_MISMATCH = 3'd2,
		ST_NOT_V2   = 3'd3,
		ST_TRUNC    = 3'd4,
		ST_BAD_SYM  = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_MARKER = 3'd1,
		PH_TABLE  = 3'd2,
		PH_DATA   = 3'd3,
		PH_DIGITS = 3'd4
	} phase_t;

endpackage

@@ sv/tspd_if.sv @@
interface tspd_enc_if import tspd_pkg::*;;
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [BYTE_W-1:0]   in_byte;

	modport source (output valid, output opcode, output in_byte, input ready);
	modport sink (input valid, input opcode, input in_byte, output ready);
endinterface

interface tspd_dec_if import tspd_pkg::*;;
	logic                valid;
	logic                ready;
	logic [BYTE_W-1:0]   out_byte;
	logic                byte_valid;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output out_byte, output byte_valid, output status,
		input ready);
	modport sink (input valid, input out_byte, input byte_valid, input status,
		output ready);
endinterface

@@ sv/text_safe_payload_decoder.sv @@
// Decodes a text-safe payload stream, one encoded byte per item, and returns exactly one
// result item for every input item: a decoded byte with its valid flag and a status code.
// A new item is accepted in every cycle while the result register is empty or being taken,
// and each result is registered and appears in the cycle after its item is accepted. Table
// lookups use the registered read port of the 203-entry symbol table memory; the 16-bit
// checksum of the decoded bytes is updated in the cycle after each result, which is always
// in time for the check digits that follow the end-of-data mark. The symbol table is not
// cleared at reset; it must be loaded by a first part before a continuation part uses it.
module text_safe_payload_decoder import tspd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	tspd_enc_if.sink   enc,
	tspd_dec_if.source dec
);

	phase_t               phase_q, phase_d;
	logic [TAB_IDX_W-1:0] tab_idx_q, tab_idx_d;
	logic                 lo_pend_q, lo_pend_d;
	logic [BYTE_W-1:0]    first_q, first_d;
	logic [CHECK_W-1:0]   chk_q, chk_d;
	logic [DCNT_W-1:0]    dcnt_q, dcnt_d;
	logic                 dend_q, dend_d;
	logic [SUM_W-1:0]     sum_q;
	logic                 sum_add_q;
	logic                 clr_sum;

	logic                 valid_s1;
	logic [BYTE_W-1:0]    ob_s1;
	logic                 bvalid_s1;
	status_t              status_s1;
	logic                 use_tab_s1;

	status_t              st_d;
	logic                 bv_d;
	logic [BYTE_W-1:0]    ob_d;
	logic                 use_tab_d;
	logic                 wr_en;
	logic                 rd_en;
	logic [BYTE_W-1:0]    rd_data;
	logic [BYTE_W-1:0]    out_byte_w;

	logic                 acc;
	op_t                  op;
	logic [BYTE_W-1:0]    c;
	logic                 is_digit;
	logic                 in_table;
	logic [CHECK_W+3:0]   chk_wide;
	logic [CHECK_W-1:0]   chk_upd;
	logic [DCNT_W-1:0]    dcnt_upd;
	logic                 last_digit;
	logic [BYTE_W-1:0]    join_tab;
	logic [BYTE_W-1:0]    rd_addr_full;

	function automatic logic [BYTE_W-1:0] join_nibbles(input logic [BYTE_W-1:0] lo,
		input logic [BYTE_W-1:0] hi);
		logic [BYTE_W-1:0] a;
		logic [BYTE_W-1:0] b;
		a = lo - BYTE_W'(NIB_BASE);
		b = hi - BYTE_W'(NIB_BASE);
		return a | {b[BYTE_W/2-1:0], {(BYTE_W/2){1'b0}}};
	endfunction

	assign enc.ready = !valid_s1 || dec.ready;
	assign acc       = enc.valid && enc.ready;
	assign op        = op_t'(enc.opcode);
	assign c         = enc.in_byte;

	assign is_digit   = (c >= BYTE_W'(DIGIT_FIRST)) && (c <= BYTE_W'(DIGIT_LAST));
	assign in_table   = (c >= BYTE_W'(TABLE_FIRST)) && (c <= BYTE_W'(TABLE_LAST));
	assign chk_wide   = ({4'b0, chk_q} << 3) + ({4'b0, chk_q} << 1)
		+ (CHECK_W+4)'(c - BYTE_W'(DIGIT_FIRST));
	assign chk_upd    = (!dend_q && is_digit) ? chk_wide[CHECK_W-1:0] : chk_q;
	assign dcnt_upd   = dcnt_q + DCNT_W'(1);
	assign last_digit = dcnt_upd >= DCNT_W'(CHECK_DIGITS);
	assign join_tab   = join_nibbles(first_q, c);
	assign rd_addr_full = c - BYTE_W'(TABLE_FIRST);

	always_comb begin
		phase_d   = phase_q;
		tab_idx_d = tab_idx_q;
		lo_pend_d = lo_pend_q;
		first_d   = first_q;
		chk_d     = chk_q;
		dcnt_d    = dcnt_q;
		dend_d    = dend_q;
		clr_sum   = 1'b0;
		case (op)
			OP_FIRST, OP_CONT: begin
				phase_d   = (op == OP_FIRST) ? PH_MARKER : PH_DATA;
				tab_idx_d = '0;
				lo_pend_d = 1'b0;
				first_d   = '0;
				chk_d     = '0;
				dcnt_d    = '0;
				dend_d    = 1'b0;
				clr_sum   = 1'b1;
			end
			OP_END: begin
				phase_d = PH_IDLE;
			end
			OP_DATA: begin
				case (phase_q)
					PH_MARKER: begin
						if (c == BYTE_W'(V2_MARK)) begin
							phase_d   = PH_TABLE;
							tab_idx_d = '0;
							lo_pend_d = 1'b0;
						end else begin
							phase_d = PH_IDLE;
						end
					end
					PH_TABLE: begin
						if (!lo_pend_q) begin
							first_d   = c;
							lo_pend_d = 1'b1;
						end else begin
							lo_pend_d = 1'b0;
							tab_idx_d = tab_idx_q + TAB_IDX_W'(1);
							if (tab_idx_q == TAB_IDX_W'(TABLE_SIZE - 1)) begin
								phase_d = PH_DATA;
							end
						end
					end
					PH_DATA: begin
						if (lo_pend_q) begin
							lo_pend_d = 1'b0;
						end else if (c == BYTE_W'(EOD_MARK)) begin
							phase_d = PH_DIGITS;
							dcnt_d  = '0;
							chk_d   = '0;
							dend_d  = 1'b0;
						end else if (in_table) begin
							phase_d = PH_DATA;
						end else if (c > BYTE_W'(TABLE_LAST)) begin
							phase_d = PH_IDLE;
						end else begin
							first_d   = c;
							lo_pend_d = 1'b1;
						end
					end
					PH_DIGITS: begin
						chk_d  = chk_upd;
						dend_d = dend_q || !is_digit;
						dcnt_d = dcnt_upd;
						if (last_digit) begin
							phase_d = PH_IDLE;
						end
					end
					default: begin
						phase_d = phase_q;
					end
				endcase
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
	end

	always_comb begin
		st_d      = ST_RUN;
		bv_d      = 1'b0;
		ob_d      = '0;
		use_tab_d = 1'b0;
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		case (op)
			OP_END: begin
				if (phase_q != PH_IDLE) begin
					st_d = ST_TRUNC;
				end
			end
			OP_DATA: begin
				case (phase_q)
					PH_MARKER: begin
						if (c != BYTE_W'(V2_MARK)) begin
							st_d = ST_NOT_V2;
						end
					end
					PH_TABLE: begin
						wr_en = acc && lo_pend_q;
					end
					PH_DATA: begin
						if (lo_pend_q) begin
							bv_d = 1'b1;
							ob_d = join_tab;
						end else if (c == BYTE_W'(EOD_MARK)) begin
							bv_d = 1'b0;
						end else if (in_table) begin
							bv_d      = 1'b1;
							use_tab_d = 1'b1;
							rd_en     = acc;
						end else if (c > BYTE_W'(TABLE_LAST)) begin
							st_d = ST_BAD_SYM;
						end
					end
					PH_DIGITS: begin
						if (last_digit) begin
							st_d = (chk_upd == {{(CHECK_W-SUM_W){1'b0}}, sum_q}) ?
								ST_GOOD : ST_MISMATCH;
						end
					end
					default: begin
						st_d = ST_RUN;
					end
				endcase
			end
			default: begin
				st_d = ST_RUN;
			end
		endcase
	end

	tspd_symtab u_symtab (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (tab_idx_q),
		.wr_data (join_tab),
		.rd_en   (rd_en),
		.rd_addr (rd_addr_full[TAB_IDX_W-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			tab_idx_q <= '0;
			lo_pend_q <= 1'b0;
			first_q   <= '0;
			chk_q     <= '0;
			dcnt_q    <= '0;
			dend_q    <= 1'b0;
		end else if (acc) begin
			phase_q   <= phase_d;
			tab_idx_q <= tab_idx_d;
			lo_pend_q <= lo_pend_d;
			first_q   <= first_d;
			chk_q     <= chk_d;
			dcnt_q    <= dcnt_d;
			dend_q    <= dend_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (dec.ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ob_s1      <= ob_d;
			bvalid_s1  <= bv_d;
			status_s1  <= st_d;
			use_tab_s1 <= use_tab_d;
		end
	end

	assign out_byte_w = use_tab_s1 ? rd_data : ob_s1;

	// The sum takes each decoded byte through the registered add flag sum_add_q, once the table read is back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q     <= '0;
			sum_add_q <= 1'b0;
		end else begin
			if (acc && clr_sum) begin
				sum_q <= '0;
			end else if (sum_add_q) begin
				sum_q <= sum_q + {{(SUM_W-BYTE_W){1'b0}}, out_byte_w};
			end
			sum_add_q <= acc && bv_d;
		end
	end

	assign dec.valid      = valid_s1;
	assign dec.out_byte   = out_byte_w;
	assign dec.byte_valid = bvalid_s1;
	assign dec.status     = status_s1;

`ifndef NO_ASSERTIONS
	a_idle_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		acc && phase_q == PH_IDLE && op == OP_DATA |=> !dec.byte_valid)
		else $error("byte decoded from an idle data item");

	a_status_idle: assert property (@(posedge clk) disable iff (!arst_n)
		acc && st_d != ST_RUN |=> phase_q == PH_IDLE)
		else $error("final status did not return the decoder to idle");

	a_sum_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		sum_add_q |-> valid_s1 && bvalid_s1)
		else $error("checksum update without a decoded byte in the result register");

	a_read_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> phase_q == PH_DATA && !lo_pend_q && wr_en == 1'b0)
		else $error("table read outside the data phase");

	a_zero_when_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !bvalid_s1 |-> out_byte_w == '0 && !use_tab_s1)
		else $error("nonzero byte on a result without a decoded byte");
`endif

endmodule

@@ sv/tspd_symtab.sv @@
module tspd_symtab import tspd_pkg::*; (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [TAB_IDX_W-1:0] wr_addr,
	input  logic [BYTE_W-1:0]    wr_data,
	input  logic                 rd_en,
	input  logic [TAB_IDX_W-1:0] rd_addr,
	output logic [BYTE_W-1:0]    rd_data
);

	logic [BYTE_W-1:0] mem [TABLE_SIZE];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
